// ===== design/ffha_pkg.sv =====
// Package for the first-fit heap allocator: sizes, status codes and the header word format.
// No dependencies.
`default_nettype none
package ffha_pkg;
    localparam int HeapBytes = 16384;
    localparam int OffW = 14;      // byte offset width
    localparam int SzW = 15;       // byte count width
    localparam int WordW = 12;     // header word index width
    localparam int HdrBytes = 12;
    localparam int SplitSlack = 16;
    localparam int HdrDepth = HeapBytes / 4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_NOMEM = 2'd2;
    localparam logic [1:0] ST_DOUBLE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    // header word: free mark in bit 15, payload size in bits 14:0
    typedef struct packed {
        logic           free;
        logic [SzW-1:0] size;
    } hdr_t;
endpackage
`default_nettype wire

// ===== design/first_fit_heap_allocator_core.sv =====
// First-fit heap allocator core: header store walk, split on allocate, coalescing on free.
// Depends on ffha_pkg.
// Each header visited passes through a read, a wait and an evaluate state. A free then
//   reads the next header unless its block ends at the heap end, and with a predecessor
//   reads that header too. Zero or null requests answer in the cycle after acceptance.
// One request at a time: a new request is accepted only in idle, after the last result is taken.
// Reset: synchronous, active low; the heap becomes one free block, used byte count zero.
// The header store needs no clearing pass: only word 0 is set at reset.
`default_nettype none
module first_fit_heap_allocator_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // tdata: operation[0], request_bytes[15:1], block_offset[29:16], zero [31:30]
    input  wire  [31:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // tdata: payload_offset[13:0], status[15:14], free_bytes[30:16], zero [31]
    output logic [31:0] m_tdata
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_EVAL, S_NXT_RD, S_NXT_EVAL,
        S_PREV_RD, S_PREV_WAIT, S_PREV_EVAL, S_OUT
    } state_t;

    hdr_t mem [HdrDepth];
    hdr_t rdata_reg;
    logic             we;
    logic [WordW-1:0] waddr, raddr;
    hdr_t             wdata;

    state_t state_reg;
    logic             op_reg;
    logic [SzW:0]     req_reg;      // rounded request, or payload offset to free
    logic [SzW:0]     off_reg;      // current block header offset
    logic [SzW:0]     prev_reg;
    logic             has_prev_reg;
    hdr_t             cur_reg;      // header of the block being allocated or freed
    logic [SzW-1:0]   used_reg;
    logic [OffW-1:0]  pay_reg;
    logic [1:0]       st_reg;
    logic             tvalid_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    logic [SzW+1:0] nxt_off;
    logic [SzW+1:0] need;
    logic           fits, split;
    assign nxt_off = {1'b0, off_reg} + (SzW+2)'(HdrBytes) + {2'b0, rdata_reg.size};
    assign need = {1'b0, req_reg} + (SzW+2)'(HdrBytes + SplitSlack);
    assign fits = rdata_reg.free && ({1'b0, rdata_reg.size} >= req_reg);
    assign split = ({2'b0, rdata_reg.size} >= need);

    always_comb begin
        we = 1'b0;
        waddr = off_reg[WordW+1:2];
        wdata = rdata_reg;
        raddr = off_reg[WordW+1:2];
        case (state_reg)
            S_EVAL: begin
                if (op_reg == OP_ALLOC && fits && split) begin
                    // split: new free tail block
                    we = 1'b1;
                    waddr = off_reg[WordW+1:2] + WordW'(HdrBytes / 4)
                            + req_reg[WordW+1:2];
                    wdata.free = 1'b1;
                    wdata.size = rdata_reg.size - SzW'(req_reg) - SzW'(HdrBytes);
                end
            end
            S_NXT_RD: raddr = nxt_off[WordW+1:2];
            S_PREV_RD, S_PREV_WAIT: raddr = prev_reg[WordW+1:2];
            S_NXT_EVAL: begin
                we = 1'b1;
                wdata.free = cur_reg.free;
                wdata.size = cur_reg.size;
                if (rdata_reg.free && cur_reg.free)
                    wdata.size = cur_reg.size + rdata_reg.size + SzW'(HdrBytes);
            end
            S_PREV_EVAL: begin
                we = rdata_reg.free;
                waddr = prev_reg[WordW+1:2];
                wdata.free = 1'b1;
                wdata.size = rdata_reg.size + cur_reg.size + SzW'(HdrBytes);
            end
            default: ;
        endcase
        if (!aresetn) begin
            we = 1'b1;
            waddr = '0;
            wdata.free = 1'b1;
            wdata.size = SzW'(HeapBytes - HdrBytes);
        end
    end

    // walk passes the heap end when offset reaches HeapBytes
    logic at_end;
    assign at_end = (off_reg >= (SzW+1)'(HeapBytes));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg <= s_tdata[0];
                        off_reg <= '0;
                        has_prev_reg <= 1'b0;
                        pay_reg <= '0;
                        if (s_tdata[0] == OP_ALLOC) begin
                            req_reg <= ({1'b0, s_tdata[15:1]} + (SzW+1)'(3))
                                       & ~(SzW+1)'(3);
                            if (s_tdata[15:1] == '0) begin
                                st_reg <= ST_IGNORED;
                                state_reg <= S_OUT;
                                tvalid_reg <= 1'b1;
                            end else state_reg <= S_RD;
                        end else begin
                            req_reg <= {2'b0, s_tdata[29:16]};
                            if (s_tdata[29:16] == '0) begin
                                st_reg <= ST_IGNORED;
                                state_reg <= S_OUT;
                                tvalid_reg <= 1'b1;
                            end else state_reg <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (at_end) begin
                        st_reg <= (op_reg == OP_ALLOC) ? ST_NOMEM : ST_IGNORED;
                        state_reg <= S_OUT;
                        tvalid_reg <= 1'b1;
                    end else state_reg <= S_WAIT;
                end
                S_WAIT: state_reg <= S_EVAL;
                S_EVAL: begin
                    if (op_reg == OP_ALLOC) begin
                        if (fits) begin
                            if (split)
                                used_reg <= used_reg + SzW'(req_reg) + SzW'(HdrBytes);
                            else
                                used_reg <= used_reg + rdata_reg.size + SzW'(HdrBytes);
                            cur_reg.free <= 1'b0;
                            cur_reg.size <= split ? SzW'(req_reg) : rdata_reg.size;
                            pay_reg <= OffW'(off_reg + (SzW+1)'(HdrBytes));
                            st_reg <= ST_OK;
                            state_reg <= S_NXT_EVAL; // writes cur_reg at off_reg
                        end else begin
                            off_reg <= nxt_off[SzW:0];
                            state_reg <= S_RD;
                        end
                    end else if (off_reg + (SzW+1)'(HdrBytes) == req_reg) begin
                        if (rdata_reg.free) begin
                            st_reg <= ST_DOUBLE;
                            state_reg <= S_OUT;
                            tvalid_reg <= 1'b1;
                        end else begin
                            used_reg <= used_reg - rdata_reg.size - SzW'(HdrBytes);
                            cur_reg.free <= 1'b1;
                            cur_reg.size <= rdata_reg.size;
                            st_reg <= ST_OK;
                            state_reg <= (nxt_off >= (SzW+2)'(HeapBytes)) ? S_NXT_EVAL
                                                                          : S_NXT_RD;
                        end
                    end else begin
                        prev_reg <= off_reg;
                        has_prev_reg <= 1'b1;
                        off_reg <= nxt_off[SzW:0];
                        state_reg <= S_RD;
                    end
                end
                S_NXT_RD: state_reg <= S_NXT_EVAL;
                S_NXT_EVAL: begin
                    // only a next block beyond the heap end leaves rdata_reg stale; then
                    // rdata holds the freed block itself, which is not free
                    if (cur_reg.free && rdata_reg.free)
                        cur_reg.size <= cur_reg.size + rdata_reg.size + SzW'(HdrBytes);
                    if (cur_reg.free && has_prev_reg) state_reg <= S_PREV_RD;
                    else begin
                        state_reg <= S_OUT;
                        tvalid_reg <= 1'b1;
                    end
                end
                S_PREV_RD: state_reg <= S_PREV_WAIT;
                S_PREV_WAIT: state_reg <= S_PREV_EVAL;
                S_PREV_EVAL: begin
                    state_reg <= S_OUT;
                    tvalid_reg <= 1'b1;
                end
                S_OUT: begin
                    if (m_tready) begin
                        tvalid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic [SzW-1:0] free_bytes;
    assign free_bytes = SzW'(HeapBytes) - used_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = tvalid_reg;
    assign m_tdata = {1'b0, free_bytes, st_reg, pay_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> state_reg == S_OUT)
        else $error("result valid outside output state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15:14] != ST_OK) |-> m_tdata[13:0] == '0)
        else $error("payload on failed request");
endmodule
`default_nettype wire

// ===== sim/first_fit_heap_allocator_core_tb.sv =====
// Testbench for first_fit_heap_allocator_core: directed and random allocate/free traffic
// checked word by word against a behavioral heap predictor. Depends on ffha_pkg and the core.
`timescale 1ns / 100ps
`default_nettype none
module first_fit_heap_allocator_core_tb;
    import ffha_pkg::*;

    typedef struct packed {
        logic [14:0] free_bytes;
        logic [1:0]  status;
        logic [13:0] pay;
    } alloc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    first_fit_heap_allocator_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // heap model: per-word size and free mark, valid only where written
    int unsigned   blk_size [HdrDepth];
    bit            blk_free [HdrDepth];
    int unsigned   model_used;
    int unsigned   live_pay [$];       // payload offsets currently allocated

    logic [31:0]   pending_words [$];
    alloc_result_t expected_results [$];
    int            mismatches = 0;
    int            results_seen = 0;
    int            n_alloc_ok = 0, n_nomem = 0, n_double = 0, n_ignored = 0;
    bit            quiet_mode = 1'b0;  // no idling on either side
    bit            sender_hold = 1'b0;
    bit            sink_hold = 1'b0;   // long receiver hold-off in progress
    bit            hold_go = 1'b0;
    int            src_gap = 0, sink_gap = 0;
    bit            stim_done = 1'b0;

    function automatic int unsigned next_block(int unsigned off);
        return off + HdrBytes + blk_size[off >> 2];
    endfunction

    function automatic alloc_result_t predict_heap(logic [31:0] w);
        alloc_result_t r;
        int unsigned off, prev, nb, req, boff;
        bit has_prev, found;
        r = '0;
        r.status = ST_OK;
        if (w[0] == OP_ALLOC) begin
            req = w[15:1];
            if (req == 0) begin
                r.status = ST_IGNORED;
            end else begin
                req = (req + 3) & ~32'd3;
                off = 0;
                found = 1'b0;
                while (off < HeapBytes && !found) begin
                    if (blk_free[off >> 2] && blk_size[off >> 2] >= req) begin
                        found = 1'b1;
                        if (blk_size[off >> 2] >= req + HdrBytes + SplitSlack) begin
                            nb = off + HdrBytes + req;
                            blk_size[nb >> 2] = blk_size[off >> 2] - req - HdrBytes;
                            blk_free[nb >> 2] = 1'b1;
                            blk_size[off >> 2] = req;
                        end
                        blk_free[off >> 2] = 1'b0;
                        model_used += blk_size[off >> 2] + HdrBytes;
                        r.pay = 14'(off + HdrBytes);
                        live_pay.push_back(off + HdrBytes);
                    end else begin
                        off = next_block(off);
                    end
                end
                if (!found) r.status = ST_NOMEM;
            end
        end else begin
            boff = w[29:16];
            off = 0;
            prev = 0;
            has_prev = 1'b0;
            if (boff == 0) begin
                r.status = ST_IGNORED;
            end else begin
                while (off < HeapBytes && off + HdrBytes != boff) begin
                    prev = off;
                    has_prev = 1'b1;
                    off = next_block(off);
                end
                if (off >= HeapBytes) begin
                    r.status = ST_IGNORED;
                end else if (blk_free[off >> 2]) begin
                    r.status = ST_DOUBLE;
                end else begin
                    blk_free[off >> 2] = 1'b1;
                    model_used -= blk_size[off >> 2] + HdrBytes;
                    nb = next_block(off);
                    if (nb < HeapBytes && blk_free[nb >> 2])
                        blk_size[off >> 2] += blk_size[nb >> 2] + HdrBytes;
                    if (has_prev && blk_free[prev >> 2])
                        blk_size[prev >> 2] += blk_size[off >> 2] + HdrBytes;
                    foreach (live_pay[i])
                        if (live_pay[i] == boff) begin
                            live_pay.delete(i);
                            break;
                        end
                end
            end
        end
        r.free_bytes = 15'(HeapBytes - model_used);
        return r;
    endfunction

    function automatic logic [31:0] alloc_word(int unsigned req);
        return {16'd0, req[14:0], OP_ALLOC};
    endfunction

    function automatic logic [31:0] free_word(int unsigned off);
        return {2'd0, off[13:0], 15'd0, OP_FREE};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got,
            want);
        mismatches++;
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    // driver: prediction is done when a word is accepted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) expected_results.push_back(predict_heap(s_tdata));
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                if (s_tvalid && s_tready) s_tvalid <= 1'b0;
            end else if ((!s_tvalid || s_tready)) begin
                if (s_tvalid && s_tready && pending_words.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0 && !sender_hold) begin
                    if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                        src_gap <= $urandom_range(1, 15);
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tdata <= pending_words.pop_front();
                        s_tvalid <= 1'b1;
                    end
                end else if (s_tvalid && s_tready) begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted in cycles here
    initial begin
        wait (hold_go);
        sink_hold = 1'b1;
        repeat (400) @(posedge aclk);
        sink_hold = 1'b0;
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        alloc_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[30:0];
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.pay != want.pay) report_mismatch("payload_offset", got.pay, want.pay);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.free_bytes != want.free_bytes)
                        report_mismatch("free_bytes", got.free_bytes, want.free_bytes);
                    case (want.status)
                        ST_OK: if (want.pay != 0) n_alloc_ok++;
                        ST_NOMEM: n_nomem++;
                        ST_DOUBLE: n_double++;
                        default: n_ignored++;
                    endcase
                end
                if (m_tdata[31]) report_mismatch("pad bit", 1, 0);
            end
            if (sink_hold) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                sink_gap <= $urandom_range(1, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
    endtask

    // random traffic: mostly allocs and frees of live blocks, some noise
    task automatic queue_random(int count, int max_req);
        int unsigned live_guess [$];
        int unsigned k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                pending_words.push_back(alloc_word($urandom_range(1, max_req)));
            end else if (k < 50) begin
                pending_words.push_back(alloc_word($urandom_range(0, 32767)));
            end else if (k < 85) begin
                // free a payload offset taken from the predictor's current live set,
                // or a likely one; the predictor resolves the truth at acceptance
                if (live_pay.size() > 0)
                    pending_words.push_back(free_word(live_pay[$urandom_range(0,
                        live_pay.size() - 1)]));
                else
                    pending_words.push_back(free_word(HdrBytes));
            end else if (k < 95) begin
                pending_words.push_back(free_word($urandom_range(0, 16383)));
            end else begin
                pending_words.push_back(free_word(0));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        blk_size[0] = HeapBytes - HdrBytes;
        blk_free[0] = 1'b1;
        model_used = 0;

        // directed: zero request, null free, tiny, split edge, whole heap, no fit, double free
        pending_words.push_back(alloc_word(0));
        pending_words.push_back(free_word(0));
        pending_words.push_back(alloc_word(1));
        pending_words.push_back(alloc_word(16384));
        pending_words.push_back(alloc_word(32767));
        pending_words.push_back(free_word(12));
        pending_words.push_back(free_word(12));
        pending_words.push_back(free_word(13));
        pending_words.push_back(free_word(16383));
        pending_words.push_back(alloc_word(HeapBytes - HdrBytes));
        pending_words.push_back(alloc_word(4));
        pending_words.push_back(free_word(12));
        pending_words.push_back(alloc_word(HeapBytes - HdrBytes - 28));
        pending_words.push_back(alloc_word(4));
        pending_words.push_back(free_word(12));
        pending_words.push_back(free_word(HeapBytes - 16));
        pending_words.push_back(alloc_word(100));
        pending_words.push_back(alloc_word(101));
        pending_words.push_back(alloc_word(102));
        pending_words.push_back(free_word(12));
        pending_words.push_back(free_word(236));
        pending_words.push_back(free_word(124));
        pending_words.push_back(alloc_word(16380));
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_go = 1'b1;
        queue_random(20, 512);
        wait_drained();

        queue_random(250, 600);
        wait_drained();
        // sender pause until all results are back
        queue_random(250, 3000);
        wait_drained();

        quiet_mode = 1'b1;
        queue_random(230, 400);
        wait_drained();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        repeat (200) @(posedge aclk);
        $display("covered %0d results: %0d allocations, %0d out of memory, %0d double frees,",
            results_seen, n_alloc_ok, n_nomem, n_double);
        $display("and %0d ignored requests", n_ignored);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
design/ffha_pkg.sv
design/first_fit_heap_allocator_core.sv
sim/first_fit_heap_allocator_core_tb.sv
